// ----- hdl/assert_macros.svh -----
// assertion macros used by the rtl of the note state tracker
// clocked on clk, disabled while rst is high; needs no other file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mnst_pkg.sv -----
// shared constants, codes and types of the midi note state tracker
// no dependencies; imported by midi_note_state_tracker
package mnst_pkg;

  localparam int NOTE_COUNT    = 128;
  localparam int CHANNEL_COUNT = 16;

  localparam int OP_W   = 3;
  localparam int CH_W   = 5;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int MASK_W = 16;

  // table rows hold an even/odd note pair
  localparam int ROWS  = (NOTE_COUNT + 1) / 2;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [NOTE_W:0]     NOTE_LIMIT = (NOTE_W + 1)'(NOTE_COUNT);
  localparam logic [CH_W-1:0]     CH_LIMIT   = CH_W'(CHANNEL_COUNT);
  localparam logic [MASK_W-1:0]   ALL_CH     = MASK_W'((64'd1 << CHANNEL_COUNT) - 64'd1);
  localparam logic [ROW_W-1:0]    LAST_ROW   = ROW_W'(ROWS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON    = 0,
    OP_NOTE_OFF   = 1,
    OP_ALL_OFF    = 2,
    OP_QUERY_CH   = 3,
    OP_QUERY_MASK = 4
  } op_t;

  typedef enum logic [2:0] {
    K_ON      = 0,
    K_OFF     = 1,
    K_OFF_IGN = 2,
    K_QUERY   = 3,
    K_PAIR    = 4,
    K_NONE    = 5,
    K_REJECT  = 6
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage

// ----- hdl/midi_note_state_tracker.sv -----
// midi note on/off state table, single module top level
// depends on mnst_pkg and assert_macros.svh

// The block keeps one 16-bit channel mask per MIDI note in a synchronous
// table of NOTE_COUNT/2 rows, each row holding an even note in its low half
// and the following odd note in its high half. Note-on, note-off and both
// queries pass an accept step (row read issued), then an execute step (read
// data back, result loaded, row written back for an accepted on or off),
// which waits while the output is still full; the block takes no new item
// before execute ends. All-notes-off walks every row once, one row per
// cycle while no pending pair waits on a busy output, then loads the
// final result in a flush step once the output is free. Cleared pairs
// are held one behind in a pending register so that the final one can
// carry last. The table needs no clearing pass: each row has a valid bit,
// cleared by reset, and a row never written reads as all zero. A read and
// a write never touch the same row in one cycle, so no forwarding is needed.
`include "assert_macros.svh"

module midi_note_state_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mnst_pkg::OP_W-1:0]   op,
  input  logic [mnst_pkg::CH_W-1:0]   channel,
  input  logic [mnst_pkg::NOTE_W-1:0] note,
  input  logic [mnst_pkg::VEL_W-1:0]  velocity,
  input  logic [mnst_pkg::MASK_W-1:0] query_mask,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 kind,
  output logic [mnst_pkg::CH_W-1:0]   out_channel,
  output logic [mnst_pkg::NOTE_W-1:0] out_note,
  output logic [mnst_pkg::VEL_W-1:0]  out_velocity,
  output logic [mnst_pkg::MASK_W-1:0] first_mask,
  output logic [mnst_pkg::MASK_W-1:0] second_mask,
  output logic                       is_on,
  output logic                       last
);
  import mnst_pkg::*;

  // note table: one row per even/odd note pair
  logic [2*MASK_W-1:0] table_mem [ROWS];
  logic [ROWS-1:0]     row_valid;
  logic [2*MASK_W-1:0] rd_data;
  logic                row_ok;

  logic                rd_en;
  logic [ROW_W-1:0]    rd_addr;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [2*MASK_W-1:0] wr_data;

  // control
  state_t state, state_next;
  logic [ROW_W-1:0] row_idx, row_idx_next;

  // latched item
  logic [OP_W-1:0]   op_q, op_q_next;
  logic [CH_W-1:0]   ch_q, ch_q_next;
  logic [NOTE_W-1:0] note_q, note_q_next;
  logic [VEL_W-1:0]  vel_q, vel_q_next;
  logic [MASK_W-1:0] qm_q, qm_q_next;

  // pending cleared pair, held back until we know whether it is the final one
  logic              pend_valid, pend_valid_next;
  logic [NOTE_W-1:0] pend_note, pend_note_next;
  logic [MASK_W-1:0] pend_ce, pend_ce_next;
  logic [MASK_W-1:0] pend_co, pend_co_next;

  // output register
  logic              out_valid_next;
  kind_t             kind_q, kind_next;
  logic [CH_W-1:0]   och_next;
  logic [NOTE_W-1:0] onote_next;
  logic [VEL_W-1:0]  ovel_next;
  logic [MASK_W-1:0] m1_next, m2_next;
  logic              on_next, last_next;

  // datapath terms
  logic                out_free;
  logic [2*MASK_W-1:0] rd_row;
  logic [MASK_W-1:0]   lo, hi, entry;
  logic                note_ok, chan_ok, pair_hit;
  logic [CH_W-1:0]     ch_m1;
  logic [MASK_W-1:0]   chan_bit, clr, ce, co, ent_new;
  logic [NOTE_W-1:0]   pair_note;

  // synchronous table, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // row valid bits stand in for clearing the table at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_ok    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        row_ok <= row_valid[rd_addr];
      end
    end
  end

  always_comb begin
    out_free  = !out_valid || out_ready;
    rd_row    = row_ok ? rd_data : '0;
    lo        = rd_row[MASK_W-1:0];
    hi        = rd_row[2*MASK_W-1:MASK_W];
    note_ok   = {1'b0, note_q} < NOTE_LIMIT;
    chan_ok   = (ch_q != '0) && (ch_q <= CH_LIMIT);
    ch_m1     = ch_q - CH_W'(1);
    chan_bit  = MASK_W'(1) << ch_m1[3:0];
    entry     = note_ok ? (note_q[0] ? hi : lo) : '0;
    // channel 0 clears everything, an out of range channel clears nothing
    clr       = (ch_q == '0) ? ALL_CH : (chan_ok ? chan_bit : '0);
    ce        = lo & clr;
    // high half of a missing odd note is never written, so it reads zero
    co        = hi & clr;
    pair_hit  = (ce | co) != '0;
    pair_note = NOTE_W'({row_idx, 1'b0});
  end

  // next state and outputs
  always_comb begin
    state_next      = state;
    row_idx_next    = row_idx;
    op_q_next       = op_q;
    ch_q_next       = ch_q;
    note_q_next     = note_q;
    vel_q_next      = vel_q;
    qm_q_next       = qm_q;
    pend_valid_next = pend_valid;
    pend_note_next  = pend_note;
    pend_ce_next    = pend_ce;
    pend_co_next    = pend_co;
    out_valid_next  = out_valid && !out_ready;
    kind_next       = kind_q;
    och_next        = out_channel;
    onote_next      = out_note;
    ovel_next       = out_velocity;
    m1_next         = first_mask;
    m2_next         = second_mask;
    on_next         = is_on;
    last_next       = last;
    in_ready        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = row_idx;
    wr_en           = 1'b0;
    wr_addr         = note_q[ROW_W:1];
    wr_data         = rd_row;
    ent_new         = entry;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_q_next   = op;
          ch_q_next   = channel;
          note_q_next = note;
          vel_q_next  = velocity;
          qm_q_next   = query_mask;
          rd_en       = 1'b1;
          if (op == OP_ALL_OFF) begin
            rd_addr         = '0;
            row_idx_next    = '0;
            pend_valid_next = 1'b0;
            state_next      = ST_WALK;
          end else begin
            rd_addr    = note[ROW_W:1];
            state_next = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          och_next       = ch_q;
          onote_next     = note_q;
          ovel_next      = '0;
          m1_next        = entry;
          m2_next        = '0;
          on_next        = 1'b0;
          last_next      = 1'b1;
          kind_next      = K_REJECT;
          priority if (op_q == OP_NOTE_ON) begin
            if (chan_ok && note_ok) begin
              ent_new   = entry | chan_bit;
              wr_en     = 1'b1;
              kind_next = K_ON;
              ovel_next = vel_q;
              m1_next   = ent_new;
            end
          end else if (op_q == OP_NOTE_OFF) begin
            if (chan_ok && note_ok && ((entry & chan_bit) != '0)) begin
              ent_new   = entry & ~chan_bit;
              wr_en     = 1'b1;
              kind_next = K_OFF;
              m1_next   = ent_new;
            end else begin
              kind_next = K_OFF_IGN;
            end
          end else if (op_q == OP_QUERY_CH) begin
            kind_next = K_QUERY;
            on_next   = chan_ok && ((entry & chan_bit) != '0);
          end else if (op_q == OP_QUERY_MASK) begin
            kind_next = K_QUERY;
            och_next  = '0;
            on_next   = (entry & qm_q) != '0;
          end else begin
            kind_next = K_REJECT;
          end
          wr_data    = note_q[0] ? {ent_new, lo} : {hi, ent_new};
          state_next = ST_IDLE;
        end
      end

      ST_WALK: begin
        // stall only when a pending pair must go out and the output is busy
        if (!(pair_hit && pend_valid && !out_free)) begin
          wr_en   = pair_hit;
          wr_addr = row_idx;
          wr_data = {hi & ~clr, lo & ~clr};
          if (pair_hit) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              kind_next      = K_PAIR;
              och_next       = ch_q;
              onote_next     = pend_note;
              ovel_next      = '0;
              m1_next        = pend_ce;
              m2_next        = pend_co;
              on_next        = 1'b0;
              last_next      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_note_next  = pair_note;
            pend_ce_next    = ce;
            pend_co_next    = co;
          end
          if (row_idx == LAST_ROW) begin
            state_next = ST_FLUSH;
          end else begin
            row_idx_next = row_idx + ROW_W'(1);
            rd_en        = 1'b1;
            rd_addr      = row_idx + ROW_W'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          och_next       = ch_q;
          ovel_next      = '0;
          on_next        = 1'b0;
          last_next      = 1'b1;
          if (pend_valid) begin
            kind_next  = K_PAIR;
            onote_next = pend_note;
            m1_next    = pend_ce;
            m2_next    = pend_co;
          end else begin
            kind_next  = K_NONE;
            onote_next = '0;
            m1_next    = '0;
            m2_next    = '0;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    row_idx      <= row_idx_next;
    op_q         <= op_q_next;
    ch_q         <= ch_q_next;
    note_q       <= note_q_next;
    vel_q        <= vel_q_next;
    qm_q         <= qm_q_next;
    pend_note    <= pend_note_next;
    pend_ce      <= pend_ce_next;
    pend_co      <= pend_co_next;
    kind_q       <= kind_next;
    out_channel  <= och_next;
    out_note     <= onote_next;
    out_velocity <= ovel_next;
    first_mask   <= m1_next;
    second_mask  <= m2_next;
    is_on        <= on_next;
    last         <= last_next;
  end

  assign kind = kind_q;

  // a row is never read and written in the same cycle
  `ASSERT_IMPLY(a_no_rw_same_row, rd_en && wr_en, rd_addr != wr_addr, "row read during write")
  // the table is not written while waiting for an item
  `ASSERT_IMPLY(a_idle_no_write, state == ST_IDLE, !wr_en, "table write while idle")
  // a held-back pair only exists inside an all-notes-off walk
  `ASSERT_IMPLY(a_pend_in_walk, pend_valid, state == ST_WALK || state == ST_FLUSH,
                "pending pair outside walk")
  // the walk ends in the flush step, never straight back to idle
  `ASSERT_NEXT(a_walk_to_flush, state == ST_WALK && state_next == ST_FLUSH,
               state == ST_FLUSH, "walk did not flush")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for midi_note_state_tracker: directed and random note traffic
// depends on mnst_pkg and the rtl of midi_note_state_tracker
module tb_top;
  import mnst_pkg::*;

  // run bounds: the cycle limit is far above the slowest legal run, the drain
  // wait covers a full table walk after the last result
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 2 * ROWS + 20;
  localparam int RANDOM_ITEMS = 270;
  localparam int MAX_PAIRS    = 64;

  // channel code that makes all-notes-off act on every channel
  localparam logic [CH_W-1:0] EVERY_CHANNEL = '0;
  // op codes with no function, the block rejects them
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // one result item as the block presents it
  typedef struct packed {
    kind_t             kind;
    logic [CH_W-1:0]   chan;
    logic [NOTE_W-1:0] note_no;
    logic [VEL_W-1:0]  vel;
    logic [MASK_W-1:0] mask_a;
    logic [MASK_W-1:0] mask_b;
    logic              on;
    logic              fin;
  } note_event_t;

  // keeps a private copy of the note table and the results still owed
  class note_table_scoreboard;
    logic [MASK_W-1:0] chan_masks [NOTE_COUNT] = '{default: '0};
    note_event_t pending_events [$];
    int errors = 0;

    function logic [MASK_W-1:0] mask_at(logic [NOTE_W-1:0] n);
      return (n < NOTE_COUNT) ? chan_masks[n] : '0;
    endfunction

    function logic channel_ok(logic [CH_W-1:0] c);
      return c >= 1 && c <= CHANNEL_COUNT;
    endfunction

    function logic [MASK_W-1:0] channel_bit(logic [CH_W-1:0] c);
      return MASK_W'(1) << ((c - 5'd1) & 5'd15);
    endfunction

    function void owe(kind_t k, logic [CH_W-1:0] c, logic [NOTE_W-1:0] n,
                      logic [VEL_W-1:0] v, logic [MASK_W-1:0] m1,
                      logic [MASK_W-1:0] m2, logic on, logic fin);
      pending_events.push_back('{k, c, n, v, m1, m2, on, fin});
    endfunction

    // note one accepted input item: update the table, queue its results
    function void apply_item(logic [OP_W-1:0] o, logic [CH_W-1:0] c,
                             logic [NOTE_W-1:0] n, logic [VEL_W-1:0] v,
                             logic [MASK_W-1:0] qm);
      logic [MASK_W-1:0] clr, ce, co;
      int pairs;
      case (o)
        OP_NOTE_ON: begin
          if (!channel_ok(c) || n >= NOTE_COUNT) begin
            owe(K_REJECT, c, n, '0, mask_at(n), '0, 1'b0, 1'b1);
          end else begin
            chan_masks[n] = chan_masks[n] | channel_bit(c);
            owe(K_ON, c, n, v, chan_masks[n], '0, 1'b0, 1'b1);
          end
        end
        OP_NOTE_OFF: begin
          if (channel_ok(c) && n < NOTE_COUNT && (chan_masks[n] & channel_bit(c)) != '0) begin
            chan_masks[n] = chan_masks[n] & ~channel_bit(c);
            owe(K_OFF, c, n, '0, chan_masks[n], '0, 1'b0, 1'b1);
          end else begin
            owe(K_OFF_IGN, c, n, '0, mask_at(n), '0, 1'b0, 1'b1);
          end
        end
        OP_ALL_OFF: begin
          if (c == EVERY_CHANNEL) clr = ALL_CH;
          else if (channel_ok(c)) clr = channel_bit(c);
          else clr = '0;
          pairs = 0;
          // grouped by even/odd note pair, only pairs that lost a bit report
          for (int e = 0; e < NOTE_COUNT; e += 2) begin
            ce = chan_masks[e] & clr;
            chan_masks[e] = chan_masks[e] & ~clr;
            co = '0;
            if (e + 1 < NOTE_COUNT) begin
              co = chan_masks[e + 1] & clr;
              chan_masks[e + 1] = chan_masks[e + 1] & ~clr;
            end
            if ((ce | co) != '0 && pairs < MAX_PAIRS) begin
              owe(K_PAIR, c, NOTE_W'(e), '0, ce, co, 1'b0, 1'b0);
              pairs++;
            end
          end
          if (pairs == 0) owe(K_NONE, c, '0, '0, '0, '0, 1'b0, 1'b1);
          else pending_events[pending_events.size() - 1].fin = 1'b1;
        end
        OP_QUERY_CH: begin
          owe(K_QUERY, c, n, '0, mask_at(n), '0,
              channel_ok(c) && (mask_at(n) & channel_bit(c)) != '0, 1'b1);
        end
        OP_QUERY_MASK: begin
          owe(K_QUERY, '0, n, '0, mask_at(n), '0, (mask_at(n) & qm) != '0, 1'b1);
        end
        default: begin
          owe(K_REJECT, c, n, '0, mask_at(n), '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    // match one accepted result against the oldest owed one
    function void check_event(note_event_t got);
      note_event_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: result expected none got kind %0d note %0d", $time,
                 got.kind, got.note_no);
        return;
      end
      want = pending_events.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("out_channel", want.chan, got.chan);
      compare_field("out_note", want.note_no, got.note_no);
      compare_field("out_velocity", want.vel, got.vel);
      compare_field("first_mask", want.mask_a, got.mask_a);
      compare_field("second_mask", want.mask_b, got.mask_b);
      compare_field("is_on", want.on, got.on);
      compare_field("last", want.fin, got.fin);
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = '0;
  logic [CH_W-1:0]   channel = '0;
  logic [NOTE_W-1:0] note = '0;
  logic [VEL_W-1:0]  velocity = '0;
  logic [MASK_W-1:0] query_mask = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [2:0]        kind;
  logic [CH_W-1:0]   out_channel;
  logic [NOTE_W-1:0] out_note;
  logic [VEL_W-1:0]  out_velocity;
  logic [MASK_W-1:0] first_mask;
  logic [MASK_W-1:0] second_mask;
  logic              is_on;
  logic              last;

  // calm turns off idling on both sides for a stretch of the random traffic
  logic calm = 1'b0;
  int   cycle_count = 0;

  note_table_scoreboard board = new;

  midi_note_state_tracker dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // result side stalls at random about 14 percent of the time unless calm, changed at the falling edge
  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 14);

  // sample both handshakes at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_event('{kind_t'(kind), out_channel, out_note, out_velocity,
                            first_mask, second_mask, is_on, last});
      if (in_valid && in_ready)
        board.apply_item(op, channel, note, velocity, query_mask);
    end
  end

  // drive one item at the falling edge, with an occasional gap first,
  // and hold it until the block takes it
  task automatic push_item(input logic [OP_W-1:0] o, input logic [CH_W-1:0] c,
                           input logic [NOTE_W-1:0] n, input logic [VEL_W-1:0] v,
                           input logic [MASK_W-1:0] qm);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 14) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    channel    <= c;
    note       <= n;
    velocity   <= v;
    query_mask <= qm;
    do @(posedge clk); while (!in_ready);
  endtask

  // most note traffic lands on a few low notes so offs and queries hit
  function automatic logic [NOTE_W-1:0] pick_note();
    return ($urandom_range(0, 99) < 70) ? NOTE_W'($urandom_range(0, 15))
                                        : NOTE_W'($urandom_range(0, NOTE_COUNT - 1));
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    return CH_W'($urandom_range(1, CHANNEL_COUNT));
  endfunction

  initial begin : stimulus
    int done, r, start;
    bit flooded;
    logic [CH_W-1:0]   c;
    logic [NOTE_W-1:0] n;
    logic [MASK_W-1:0] m, qm;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, rejects, ignored offs, queries, clears
    push_item(OP_QUERY_CH, 5'd1, 7'd0, 7'd0, 16'h0000);
    push_item(OP_NOTE_ON, 5'd1, 7'd0, 7'd127, 16'hffff);
    push_item(OP_NOTE_ON, 5'd16, 7'd127, 7'd0, 16'h0000);
    push_item(OP_NOTE_ON, 5'd16, 7'd0, 7'd85, 16'h5555);
    // note-on with channel zero or above the last channel is rejected
    push_item(OP_NOTE_ON, 5'd0, 7'd5, 7'd42, 16'haaaa);
    push_item(OP_NOTE_ON, 5'd31, 7'd127, 7'd127, 16'hffff);
    push_item(OP_QUERY_CH, 5'd16, 7'd127, 7'd0, 16'h0000);
    // query on a channel out of range answers off
    push_item(OP_QUERY_CH, 5'd0, 7'd0, 7'd0, 16'h0000);
    push_item(OP_QUERY_CH, 5'd17, 7'd0, 7'd0, 16'h0000);
    push_item(OP_QUERY_MASK, 5'd31, 7'd0, 7'd0, 16'hffff);
    push_item(OP_QUERY_MASK, 5'd3, 7'd0, 7'd0, 16'h0000);
    push_item(OP_QUERY_MASK, 5'd0, 7'd127, 7'd0, 16'h8000);
    push_item(OP_NOTE_OFF, 5'd1, 7'd0, 7'd127, 16'h0000);
    // off of a note that is not sounding, or on a bad channel, is ignored
    push_item(OP_NOTE_OFF, 5'd1, 7'd0, 7'd0, 16'h0000);
    push_item(OP_NOTE_OFF, 5'd0, 7'd127, 7'd0, 16'h0000);
    push_item(OP_NOTE_OFF, 5'd31, 7'd127, 7'd0, 16'h0000);
    push_item(OP_ALL_OFF, 5'd16, 7'd0, 7'd0, 16'h0000);
    // nothing left on channel 16, a single none-cleared result
    push_item(OP_ALL_OFF, 5'd16, 7'd99, 7'd0, 16'h0000);
    push_item(OP_NOTE_ON, 5'd5, 7'd1, 7'd64, 16'h0000);
    push_item(OP_NOTE_ON, 5'd9, 7'd2, 7'd1, 16'h0000);
    // clear on a channel out of range clears nothing
    push_item(OP_ALL_OFF, 5'd20, 7'd0, 7'd0, 16'h0000);
    push_item(OP_ALL_OFF, EVERY_CHANNEL, 7'd0, 7'd0, 16'h0000);
    push_item(OP_ALL_OFF, EVERY_CHANNEL, 7'd0, 7'd0, 16'h0000);
    // unused op codes are rejected
    for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++)
      push_item(OP_W'(o), CH_W'($urandom_range(0, 31)), NOTE_W'($urandom_range(0, 127)),
                VEL_W'($urandom), MASK_W'($urandom));

    // random: mostly well-formed note traffic, some clears, some noise
    done = 0;
    flooded = 1'b0;
    while (done < RANDOM_ITEMS) begin
      calm = (done >= 100 && done < 160);
      if (!flooded && done >= 40) begin
        // one note per pair, then a full clear: the longest result burst
        flooded = 1'b1;
        for (int e = 0; e < NOTE_COUNT; e += 2) begin
          n = NOTE_W'((e + 1 < NOTE_COUNT) ? e + $urandom_range(0, 1) : e);
          push_item(OP_NOTE_ON, pick_channel(), n, VEL_W'($urandom), MASK_W'($urandom));
          done++;
        end
        push_item(OP_ALL_OFF, EVERY_CHANNEL, NOTE_W'($urandom), VEL_W'($urandom),
                  MASK_W'($urandom));
        done++;
        continue;
      end
      r = $urandom_range(0, 99);
      n = pick_note();
      c = pick_channel();
      qm = MASK_W'($urandom);
      if (r < 34) begin
        push_item(OP_NOTE_ON, c, n, VEL_W'($urandom), qm);
      end else if (r < 56) begin
        // mostly release a channel the note is really sounding on
        m = board.mask_at(n);
        if (m != '0 && $urandom_range(0, 3) != 0) begin
          start = $urandom_range(0, 15);
          for (int k = 0; k < 16; k++)
            if (m[(start + k) % 16]) c = CH_W'((start + k) % 16 + 1);
        end
        push_item(OP_NOTE_OFF, c, n, VEL_W'($urandom), qm);
      end else if (r < 70) begin
        push_item(OP_QUERY_CH, c, n, VEL_W'($urandom), qm);
      end else if (r < 82) begin
        if ($urandom_range(0, 1) != 0) qm = MASK_W'(1) << $urandom_range(0, 15);
        push_item(OP_QUERY_MASK, CH_W'($urandom), n, VEL_W'($urandom), qm);
      end else if (r < 88) begin
        r = $urandom_range(0, 9);
        if (r < 3) c = EVERY_CHANNEL;
        else if (r == 3) c = CH_W'($urandom_range(CHANNEL_COUNT + 1, 31));
        push_item(OP_ALL_OFF, c, NOTE_W'($urandom), VEL_W'($urandom), qm);
      end else begin
        push_item(OP_W'($urandom_range(0, 7)), CH_W'($urandom_range(0, 31)),
                  NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom), qm);
      end
      done++;
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // let every owed result arrive, then watch for strays over a full walk
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
